// ----- rtl/lcdnw_pkg.sv -----
// Package for the character LCD nibble writer.
// Holds command codes, the byte-operation type and the init sequence tables.
// No dependencies.
package lcdnw_pkg;

  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_PUTC  = 3'd1;
  localparam logic [2:0] CMD_RAW   = 3'd2;
  localparam logic [2:0] CMD_GOTO  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [7:0] CH_FORM_FEED = 8'h0C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;

  localparam logic [1:0] EMIT_PRE = 2'd0;
  localparam logic [1:0] EMIT_HI  = 2'd1;
  localparam logic [1:0] EMIT_LO  = 2'd2;

  localparam int         INIT_LEN  = 21;
  localparam logic [4:0] INIT_LAST = 5'(INIT_LEN - 1);
  localparam logic [1:0] PRE_LAST  = 2'd3;

  typedef struct packed {
    logic [7:0]  data;
    logic        rs;
    logic [13:0] lead;
    logic [13:0] trail;
  } byte_op_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic [13:0] lead;
    logic [13:0] trail;
  } pre_op_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       load_rom;
    logic [4:0] rom_idx;
    logic       emit;
    logic [1:0] emit_sel;
    logic [1:0] pre_idx;
    logic       last;
  } ctrl_cmd_t;

  localparam byte_op_t OP_CLEAR = '{8'h01, 1'b0, 14'd80, 14'd2040};

  function automatic byte_op_t init_op(input logic [4:0] idx);
    byte_op_t op;
    op = OP_CLEAR;
    case (idx)
      5'd0:  op = '{8'h28, 1'b0, 14'd40, 14'd90};
      5'd1:  op = '{8'h0C, 1'b0, 14'd40, 14'd90};
      5'd2:  op = '{8'h01, 1'b0, 14'd80, 14'd2090};
      5'd3:  op = '{8'h06, 1'b0, 14'd40, 14'd90};
      5'd4:  op = '{8'h40, 1'b0, 14'd40, 14'd40};
      5'd5:  op = '{8'h0A, 1'b1, 14'd40, 14'd40};
      5'd6:  op = '{8'h1F, 1'b1, 14'd40, 14'd40};
      5'd7:  op = '{8'h0E, 1'b1, 14'd40, 14'd40};
      5'd8:  op = '{8'h1F, 1'b1, 14'd40, 14'd40};
      5'd9:  op = '{8'h0E, 1'b1, 14'd40, 14'd40};
      5'd10: op = '{8'h1F, 1'b1, 14'd40, 14'd40};
      5'd11: op = '{8'h0E, 1'b1, 14'd40, 14'd40};
      5'd12: op = '{8'h00, 1'b1, 14'd40, 14'd40};
      5'd13: op = '{8'h02, 1'b1, 14'd40, 14'd40};
      5'd14: op = '{8'h04, 1'b1, 14'd40, 14'd40};
      5'd15: op = '{8'h0E, 1'b1, 14'd40, 14'd40};
      5'd16: op = '{8'h11, 1'b1, 14'd40, 14'd40};
      5'd17: op = '{8'h1F, 1'b1, 14'd40, 14'd40};
      5'd18: op = '{8'h10, 1'b1, 14'd40, 14'd40};
      5'd19: op = '{8'h0E, 1'b1, 14'd40, 14'd40};
      5'd20: op = OP_CLEAR;
      default: op = OP_CLEAR;
    endcase
    return op;
  endfunction

  function automatic pre_op_t pre_strobe(input logic [1:0] idx);
    pre_op_t p;
    case (idx)
      2'd0:    p = '{4'h3, 14'd15000, 14'd5000};
      2'd1:    p = '{4'h3, 14'd0, 14'd200};
      2'd2:    p = '{4'h3, 14'd0, 14'd200};
      default: p = '{4'h2, 14'd0, 14'd0};
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/char_lcd_nibble_writer.sv -----
// Top level of the character LCD nibble writer (4-bit interface front end).
// Depends on lcdnw_pkg, lcdnw_ctrl and lcdnw_dp.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   in      | input     | in_valid / in_ready  | cmd, char_code, position
//   out     | output    | out_valid / out_ready| nibble, reg_select, waits, last
//
// Flow: a command is accepted while the sequencer is idle, then one strobe per cycle
//   while the result side takes them: the high and low nibble of a byte command, or
//   the init preamble and table. lcdnw_ctrl sequences them, one command at a time.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// Stalls: out_ready low while the output is valid holds the output register and freezes
//   the sequencer; in_ready is high only while the sequencer is idle.
// Commands 5 to 7 are accepted and produce no strobes.
module char_lcd_nibble_writer
  import lcdnw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [6:0]  in_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_nibble,
  output logic        out_reg_select,
  output logic [13:0] out_wait_before_us,
  output logic [13:0] out_wait_after_us,
  output logic        out_last
);

  ctrl_cmd_t cmd;
  logic      out_free;

  // Sequencer: walks preamble, byte high/low strobes and the init table
  lcdnw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  // Datapath: holds the current byte op and the registered strobe
  lcdnw_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_cmd             (in_cmd),
    .in_char_code       (in_char_code),
    .in_position        (in_position),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_nibble         (out_nibble),
    .out_reg_select     (out_reg_select),
    .out_wait_before_us (out_wait_before_us),
    .out_wait_after_us  (out_wait_after_us),
    .out_last           (out_last)
  );

endmodule

// ----- rtl/lcdnw_ctrl.sv -----
// Sequencing state machine for the LCD nibble writer.
// Depends on lcdnw_pkg; drives ctrl_cmd_t to lcdnw_dp.
module lcdnw_ctrl
  import lcdnw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_cmd,
  output logic       in_ready,
  input  logic       out_free,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PRE  = 2'd1;
  localparam logic [1:0] S_HI   = 2'd2;
  localparam logic [1:0] S_LO   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic       init_r, init_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    init_nxt  = init_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_INIT: begin
              init_nxt  = 1'b1;
              idx_nxt   = '0;
              state_nxt = S_PRE;
            end
            CMD_PUTC, CMD_RAW, CMD_GOTO, CMD_CLEAR: begin
              cmd.load_in = 1'b1;
              init_nxt    = 1'b0;
              state_nxt   = S_HI;
            end
            default: ;  // drop unknown commands
          endcase
        end
      end
      S_PRE: begin
        if (out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_PRE;
          cmd.pre_idx  = idx_r[1:0];
          if (idx_r[1:0] == PRE_LAST) begin
            cmd.load_rom = 1'b1;
            cmd.rom_idx  = '0;
            idx_nxt      = '0;
            state_nxt    = S_HI;
          end else begin
            idx_nxt = idx_r + 5'd1;
          end
        end
      end
      S_HI: begin
        if (out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_HI;
          state_nxt    = S_LO;
        end
      end
      S_LO: begin
        if (out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_LO;
          if (init_r && idx_r != INIT_LAST) begin
            cmd.load_rom = 1'b1;
            cmd.rom_idx  = idx_r + 5'd1;
            idx_nxt      = idx_r + 5'd1;
            state_nxt    = S_HI;
          end else begin
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      init_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      init_r  <= init_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= INIT_LAST)
    else $error("init index out of range");

  a_pre_only_init: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PRE |-> init_r && idx_r <= 5'd3)
    else $error("preamble state outside init run");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && cmd.last |=> state_r == S_IDLE)
    else $error("last strobe did not return to idle");

  a_load_needs_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("strobe emitted into a full output register");

endmodule

// ----- rtl/lcdnw_dp.sv -----
// Datapath for the LCD nibble writer: byte-op register, decode, output register.
// Depends on lcdnw_pkg; driven by lcdnw_ctrl through ctrl_cmd_t.
module lcdnw_dp
  import lcdnw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [6:0]  in_position,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_nibble,
  output logic        out_reg_select,
  output logic [13:0] out_wait_before_us,
  output logic [13:0] out_wait_after_us,
  output logic        out_last
);

  byte_op_t op_r;
  byte_op_t in_op;
  pre_op_t  pre;
  logic        out_valid_r;
  logic [3:0]  nibble_r;
  logic        rs_r;
  logic [13:0] before_r;
  logic [13:0] after_r;
  logic        last_r;

  // Decode a single-byte command into its byte op
  always_comb begin
    in_op = OP_CLEAR;
    case (in_cmd)
      CMD_PUTC: begin
        if (in_char_code == CH_FORM_FEED)
          in_op = OP_CLEAR;
        else if (in_char_code == CH_NEWLINE)
          in_op = '{8'hC0, 1'b0, 14'd40, 14'd40};
        else if (in_char_code == CH_CR)
          in_op = '{8'h80, 1'b0, 14'd40, 14'd40};
        else
          in_op = '{in_char_code, 1'b1, 14'd40, 14'd40};
      end
      CMD_RAW:  in_op = '{in_char_code, 1'b1, 14'd40, 14'd40};
      CMD_GOTO: in_op = '{{1'b1, in_position}, 1'b0, 14'd40, 14'd40};
      default:  in_op = OP_CLEAR;
    endcase
  end

  assign pre      = pre_strobe(cmd.pre_idx);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in)
      op_r <= in_op;
    else if (cmd.load_rom)
      op_r <= init_op(cmd.rom_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (cmd.emit)
      out_valid_r <= 1'b1;
    else if (out_ready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_r <= cmd.last;
      case (cmd.emit_sel)
        EMIT_PRE: begin
          nibble_r <= pre.nibble;
          rs_r     <= 1'b0;
          before_r <= pre.lead;
          after_r  <= pre.trail;
        end
        EMIT_HI: begin
          nibble_r <= op_r.data[7:4];
          rs_r     <= op_r.rs;
          before_r <= op_r.lead;
          after_r  <= '0;
        end
        default: begin
          nibble_r <= op_r.data[3:0];
          rs_r     <= op_r.rs;
          before_r <= '0;
          after_r  <= op_r.trail;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_nibble         = nibble_r;
  assign out_reg_select     = rs_r;
  assign out_wait_before_us = before_r;
  assign out_wait_after_us  = after_r;
  assign out_last           = last_r;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for char_lcd_nibble_writer: directed table, then random commands.
// Depends on lcdnw_pkg for command codes and special characters.
module tb_top;
  import lcdnw_pkg::*;

  // Command values the block accepts but turns into no strobes
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // LCD instruction bytes and register-select levels
  localparam logic [7:0] CLR_DISPLAY = 8'h01;
  localparam logic [7:0] DDRAM_SET = 8'h80;
  localparam logic [7:0] ROW2_ADDR = 8'h40;
  localparam logic       RS_CMD    = 1'b0;
  localparam logic       RS_DATA   = 1'b1;

  // Waits in microseconds
  localparam logic [13:0] T_WR        = 14'd40;
  localparam logic [13:0] T_SETUP     = 14'd90;
  localparam logic [13:0] T_CLR_PRE   = 14'd80;
  localparam logic [13:0] T_CLR_POST  = 14'd2040;
  localparam logic [13:0] T_CLR_INIT  = 14'd2090;
  localparam logic [13:0] T_PWR_UP    = 14'd15000;
  localparam logic [13:0] T_WAKE1     = 14'd5000;
  localparam logic [13:0] T_WAKE      = 14'd200;

  // Power-up byte sequence after the four wake-up nibbles
  localparam int INIT_BYTES_N = 21;
  localparam int GLYPH_FIRST  = 5;
  localparam int GLYPH_LAST   = 19;
  localparam logic [7:0] INIT_BYTES [INIT_BYTES_N] = '{
    8'h28, 8'h0C, 8'h01, 8'h06, 8'h40,
    8'h0A, 8'h1F, 8'h0E, 8'h1F, 8'h0E, 8'h1F, 8'h0E, 8'h00,
    8'h02, 8'h04, 8'h0E, 8'h11, 8'h1F, 8'h10, 8'h0E,
    8'h01
  };

  // How a table row gets its expectation
  localparam logic [1:0] ROW_PREDICT = 2'd0;
  localparam logic [1:0] ROW_BYTE    = 2'd1;
  localparam logic [1:0] ROW_SILENT  = 2'd2;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RAND_PER_PHASE = 72;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic [13:0] lead;
    logic [13:0] trail;
    logic        last;
  } lcd_strobe_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  cmd;
    logic [7:0]  ch;
    logic [6:0]  pos;
    logic [7:0]  t_byte;
    logic        t_rs;
    logic [13:0] t_before;
    logic [13:0] t_after;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_cmd = CMD_INIT;
  logic [7:0]  in_char_code = 8'h00;
  logic [6:0]  in_position = 7'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_nibble;
  logic        out_reg_select;
  logic [13:0] out_wait_before_us;
  logic [13:0] out_wait_after_us;
  logic        out_last;

  lcd_strobe_t strobe_q[$];
  int          cycle_cnt = 0;
  int          err_cnt = 0;
  int          strobes_checked = 0;
  int          cmd_seen [8];
  int          tx_idle_pct = 20;
  int          rx_idle_pct = 56;

  char_lcd_nibble_writer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_char_code       (in_char_code),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_nibble         (out_nibble),
    .out_reg_select     (out_reg_select),
    .out_wait_before_us (out_wait_before_us),
    .out_wait_after_us  (out_wait_after_us),
    .out_last           (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count a mismatch and print one line for it
  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
  endtask

  function automatic void queue_strobe(input logic [3:0] nib, input logic rs,
                                       input logic [13:0] bef, input logic [13:0] aft,
                                       input logic last);
    strobe_q.push_back('{nib, rs, bef, aft, last});
  endfunction

  // A byte write: high nibble carries the leading wait, low nibble the trailing one
  function automatic void queue_byte(input logic [7:0] b, input logic rs,
                                     input logic [13:0] bef, input logic [13:0] aft,
                                     input logic last);
    queue_strobe(b[7:4], rs, bef, 14'd0, 1'b0);
    queue_strobe(b[3:0], rs, 14'd0, aft, last);
  endfunction

  // Expected strobe run for one accepted command
  function automatic void predict_strobes(input logic [2:0] cmd, input logic [7:0] ch,
                                          input logic [6:0] pos);
    logic        rs;
    logic [13:0] bef;
    logic [13:0] aft;
    case (cmd)
      CMD_INIT: begin
        // Wake-up: three 8-bit function sets, then switch to 4-bit mode
        queue_strobe(4'h3, RS_CMD, T_PWR_UP, T_WAKE1, 1'b0);
        queue_strobe(4'h3, RS_CMD, 14'd0, T_WAKE, 1'b0);
        queue_strobe(4'h3, RS_CMD, 14'd0, T_WAKE, 1'b0);
        queue_strobe(4'h2, RS_CMD, 14'd0, 14'd0, 1'b0);
        for (int i = 0; i < INIT_BYTES_N; i++) begin
          rs  = (i >= GLYPH_FIRST && i <= GLYPH_LAST) ? RS_DATA : RS_CMD;
          bef = T_WR;
          aft = T_WR;
          if (i == 2) begin
            bef = T_CLR_PRE;
            aft = T_CLR_INIT;
          end else if (i == INIT_BYTES_N - 1) begin
            bef = T_CLR_PRE;
            aft = T_CLR_POST;
          end else if (i < 4) begin
            aft = T_SETUP;
          end
          queue_byte(INIT_BYTES[i], rs, bef, aft, i == INIT_BYTES_N - 1);
        end
      end
      CMD_PUTC: begin
        if (ch == CH_FORM_FEED)
          queue_byte(CLR_DISPLAY, RS_CMD, T_CLR_PRE, T_CLR_POST, 1'b1);
        else if (ch == CH_NEWLINE)
          queue_byte(DDRAM_SET | ROW2_ADDR, RS_CMD, T_WR, T_WR, 1'b1);
        else if (ch == CH_CR)
          queue_byte(DDRAM_SET, RS_CMD, T_WR, T_WR, 1'b1);
        else
          queue_byte(ch, RS_DATA, T_WR, T_WR, 1'b1);
      end
      CMD_RAW:   queue_byte(ch, RS_DATA, T_WR, T_WR, 1'b1);
      CMD_GOTO:  queue_byte(DDRAM_SET + {1'b0, pos}, RS_CMD, T_WR, T_WR, 1'b1);
      CMD_CLEAR: queue_byte(CLR_DISPLAY, RS_CMD, T_CLR_PRE, T_CLR_POST, 1'b1);
      default: ;
    endcase
  endfunction

  // Drive one item from the falling edge, hold it until accepted, then record
  // what it should produce. Returns at a falling edge with valid still high.
  task automatic send_item(input stim_row_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= r.cmd;
    in_char_code <= r.ch;
    in_position  <= r.pos;
    do @(posedge clk); while (!(in_valid && in_ready));
    cmd_seen[r.cmd]++;
    case (r.kind)
      ROW_BYTE:   queue_byte(r.t_byte, r.t_rs, r.t_before, r.t_after, 1'b1);
      ROW_SILENT: ;
      default:    predict_strobes(r.cmd, r.ch, r.pos);
    endcase
    @(negedge clk);
  endtask

  // Random command mix: mostly byte traffic with special characters favored,
  // a few power-up runs and a few ignored command values
  function automatic stim_row_t random_item();
    stim_row_t r;
    int pick;
    r      = '0;
    r.kind = ROW_PREDICT;
    r.ch   = 8'($urandom_range(255));
    r.pos  = 7'($urandom_range(127));
    pick   = $urandom_range(99);
    if (pick < 5)       r.cmd = CMD_INIT;
    else if (pick < 35) r.cmd = CMD_PUTC;
    else if (pick < 58) r.cmd = CMD_RAW;
    else if (pick < 78) r.cmd = CMD_GOTO;
    else if (pick < 90) r.cmd = CMD_CLEAR;
    else                r.cmd = 3'($urandom_range(7, 5));
    if (r.cmd == CMD_PUTC && $urandom_range(3) == 0) begin
      case ($urandom_range(2))
        0:       r.ch = CH_FORM_FEED;
        1:       r.ch = CH_NEWLINE;
        default: r.ch = CH_CR;
      endcase
    end
    return r;
  endfunction

  // Receiver: drop ready at random, changed on the falling edge only
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= rx_idle_pct);

  // Cycle watchdog and result checker, sampled at the rising edge
  always @(posedge clk) begin
    lcd_strobe_t e;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d strobes outstanding", cycle_cnt,
               strobe_q.size());
      $display("char_lcd_nibble_writer test failed");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      if (strobe_q.size() == 0) begin
        report_mismatch($sformatf("unexpected strobe nibble %h rs %b",
                                  out_nibble, out_reg_select));
      end else begin
        e = strobe_q.pop_front();
        strobes_checked++;
        if (out_nibble !== e.nibble)
          report_mismatch($sformatf("nibble %h, want %h", out_nibble, e.nibble));
        if (out_reg_select !== e.rs)
          report_mismatch($sformatf("reg_select %b, want %b", out_reg_select, e.rs));
        if (out_wait_before_us !== e.lead)
          report_mismatch($sformatf("wait_before %0d, want %0d",
                                    out_wait_before_us, e.lead));
        if (out_wait_after_us !== e.trail)
          report_mismatch($sformatf("wait_after %0d, want %0d",
                                    out_wait_after_us, e.trail));
        if (out_last !== e.last)
          report_mismatch($sformatf("last %b, want %b", out_last, e.last));
      end
    end
  end

  // Directed rows: field extremes, every command, the special characters,
  // the ignored command values, and back-to-back power-up runs
  stim_row_t dir_tab [23];

  initial begin
    stim_row_t row;
    int        n;

    dir_tab = '{
      '{ROW_PREDICT, CMD_INIT,  8'h00, 7'h00, 8'h00, RS_CMD, 14'd0, 14'd0},
      '{ROW_BYTE,    CMD_CLEAR, 8'h00, 7'h00, CLR_DISPLAY, RS_CMD, T_CLR_PRE, T_CLR_POST},
      '{ROW_BYTE,    CMD_GOTO,  8'h00, 7'h00, 8'h80, RS_CMD, T_WR, T_WR},
      '{ROW_BYTE,    CMD_GOTO,  8'hFF, 7'h7F, 8'hFF, RS_CMD, T_WR, T_WR},
      '{ROW_BYTE,    CMD_PUTC,  CH_FORM_FEED, 7'h7F, CLR_DISPLAY, RS_CMD, T_CLR_PRE,
        T_CLR_POST},
      '{ROW_BYTE,    CMD_PUTC,  CH_NEWLINE, 7'h00, 8'hC0, RS_CMD, T_WR, T_WR},
      '{ROW_BYTE,    CMD_PUTC,  CH_CR, 7'h00, 8'h80, RS_CMD, T_WR, T_WR},
      '{ROW_BYTE,    CMD_PUTC,  8'h00, 7'h00, 8'h00, RS_DATA, T_WR, T_WR},
      '{ROW_BYTE,    CMD_PUTC,  8'hFF, 7'h7F, 8'hFF, RS_DATA, T_WR, T_WR},
      '{ROW_PREDICT, CMD_PUTC,  8'h41, 7'h15, 8'h00, RS_CMD, 14'd0, 14'd0},
      '{ROW_BYTE,    CMD_RAW,   8'h00, 7'h7F, 8'h00, RS_DATA, T_WR, T_WR},
      '{ROW_BYTE,    CMD_RAW,   8'hFF, 7'h00, 8'hFF, RS_DATA, T_WR, T_WR},
      '{ROW_BYTE,    CMD_RAW,   CH_FORM_FEED, 7'h00, CH_FORM_FEED, RS_DATA, T_WR, T_WR},
      '{ROW_PREDICT, CMD_RAW,   CH_NEWLINE, 7'h2A, 8'h00, RS_CMD, 14'd0, 14'd0},
      '{ROW_PREDICT, CMD_RAW,   CH_CR, 7'h55, 8'h00, RS_CMD, 14'd0, 14'd0},
      '{ROW_SILENT,  CMD_RSVD5, 8'h00, 7'h00, 8'h00, RS_CMD, 14'd0, 14'd0},
      '{ROW_SILENT,  CMD_RSVD6, 8'h5A, 7'h2A, 8'h00, RS_CMD, 14'd0, 14'd0},
      '{ROW_SILENT,  CMD_RSVD7, 8'hFF, 7'h7F, 8'h00, RS_CMD, 14'd0, 14'd0},
      '{ROW_PREDICT, CMD_PUTC,  8'h0B, 7'h00, 8'h00, RS_CMD, 14'd0, 14'd0},
      '{ROW_PREDICT, CMD_PUTC,  8'h0E, 7'h00, 8'h00, RS_CMD, 14'd0, 14'd0},
      '{ROW_PREDICT, CMD_GOTO,  8'h00, 7'h40, 8'h00, RS_CMD, 14'd0, 14'd0},
      '{ROW_PREDICT, CMD_INIT,  8'hA5, 7'h33, 8'h00, RS_CMD, 14'd0, 14'd0},
      '{ROW_PREDICT, CMD_INIT,  8'h00, 7'h00, 8'h00, RS_CMD, 14'd0, 14'd0}
    };

    // Hold reset, then release it on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part runs with the first idle mix
    for (int i = 0; i < $size(dir_tab); i++)
      send_item(dir_tab[i]);

    // Random part in three idle mixes: sender light / receiver heavy,
    // the reverse, then full throughput
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 56;
        end
        1: begin
          tx_idle_pct = 56;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      n = 0;
      while (n < RAND_PER_PHASE) begin
        row = random_item();
        send_item(row);
        // ignored command values do not count toward the phase
        if (row.cmd <= CMD_CLEAR)
          n++;
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected strobe, then allow for stray output
    while (strobe_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (strobe_q.size() != 0)
      report_mismatch($sformatf("%0d strobes never arrived", strobe_q.size()));

    $display("run: %0d init, %0d put-char, %0d raw, %0d goto, %0d clear, %0d ignored",
             cmd_seen[CMD_INIT], cmd_seen[CMD_PUTC], cmd_seen[CMD_RAW],
             cmd_seen[CMD_GOTO], cmd_seen[CMD_CLEAR],
             cmd_seen[CMD_RSVD5] + cmd_seen[CMD_RSVD6] + cmd_seen[CMD_RSVD7]);
    $display("%0d strobes compared over %0d cycles, %0d mismatches",
             strobes_checked, cycle_cnt, err_cnt);
    if (err_cnt == 0)
      $display("char_lcd_nibble_writer test passed");
    else
      $display("char_lcd_nibble_writer test failed");
    $finish;
  end

endmodule
